>>> src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants for the 1-D Lagrange basis and derivative core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbd_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  // running products and derivative sums saturate at +-2^34
  localparam int ACC_W = 36;
  typedef logic signed [ACC_W-1:0] acc_t;
  localparam acc_t ACC_MAX = 36'sd17179869184;
  localparam acc_t ACC_MIN = -36'sd17179869184;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD  = 4'd1;

  typedef struct packed {
    logic [3:0] order;
    logic       grad;
  } lbd_cfg_t;

endpackage

>>> src/lbd_qmul.sv
// ----------------------------------------------------------------------------
// lbd_qmul
// Shared fixed-point multiplier: registered product, then rounding to nearest
// (ties away from zero) and saturation to the accumulator range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbd_qmul import lbd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BW        = 21
) (
  input  logic                 clk,
  input  acc_t                 a,
  input  logic signed [BW-1:0] b,
  output acc_t                 res
);

  localparam int PW = ACC_W + BW;
  localparam logic signed [PW:0] HALF   = (PW+1)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [PW:0] HALF_M = HALF - (PW+1)'(1);
  localparam logic signed [PW:0] LIM_HI = (PW+1)'(ACC_MAX);
  localparam logic signed [PW:0] LIM_LO = (PW+1)'(ACC_MIN);

  logic signed [PW-1:0] prod;
  logic signed [PW:0]   sum;
  logic signed [PW:0]   quo;

  always_ff @(posedge clk) begin
    prod <= PW'(a) * PW'(b);
  end

  always_comb begin
    sum = (PW+1)'(prod) + (prod[PW-1] ? HALF_M : HALF);
    quo = sum >>> FRAC_BITS;
    if (quo > LIM_HI) begin
      res = ACC_MAX;
    end else if (quo < LIM_LO) begin
      res = ACC_MIN;
    end else begin
      res = ACC_W'(quo);
    end
  end

endmodule

>>> src/lbd_ctrl.sv
// ----------------------------------------------------------------------------
// lbd_ctrl
// Sequencer for the basis and derivative product chains, operand selection,
// reciprocal table, derivative accumulation and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbd_ctrl import lbd_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = $clog2(MAX_ORDER + 1),
  localparam int BW = NW + FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [16:0]          coord,
  input  lbd_cfg_t             cfg,
  output logic                 busy,
  output acc_t                 op_a,
  output logic signed [BW-1:0] op_b,
  input  acc_t                 op_res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [3:0]           node_index,
  output logic signed [31:0]   shape_value,
  output logic signed [31:0]   derivative_value,
  output logic                 last_node
);

  localparam int VW    = NW + FRAC_BITS;
  localparam int UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int RND   = (1 << DN) >> 1;
  localparam int SW    = NW + 17 + UP;
  localparam int DW    = ACC_W + NW + 1;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int RW    = FRAC_BITS + 1;

  localparam logic [RW-1:0] RECIP [12] = '{
    RW'((ONE_I + 0) / 1),  RW'((ONE_I + 1) / 2),  RW'((ONE_I + 1) / 3),
    RW'((ONE_I + 2) / 4),  RW'((ONE_I + 2) / 5),  RW'((ONE_I + 3) / 6),
    RW'((ONE_I + 3) / 7),  RW'((ONE_I + 4) / 8),  RW'((ONE_I + 4) / 9),
    RW'((ONE_I + 5) / 10), RW'((ONE_I + 5) / 11), RW'((ONE_I + 6) / 12)
  };

  localparam acc_t ACC_ONE = acc_t'(longint'(1) << FRAC_BITS);
  localparam logic signed [ACC_W:0] SUM_HI = (ACC_W+1)'(ACC_MAX);
  localparam logic signed [ACC_W:0] SUM_LO = (ACC_W+1)'(ACC_MIN);
  localparam acc_t SHP_HI = ACC_W'(32'sh7fffffff);
  localparam acc_t SHP_LO = ACC_W'(32'sh80000000);
  localparam logic signed [DW-1:0] DRV_HI = DW'(32'sh7fffffff);
  localparam logic signed [DW-1:0] DRV_LO = DW'(32'sh80000000);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_RND   = 3'd2;
  localparam logic [2:0] S_CHAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    st;
  logic [VW-1:0] v;
  logic [NW-1:0] j;
  logic [NW-1:0] c;
  logic [NW-1:0] k;
  logic          deriv;
  logic          sub;
  acc_t          acc;
  acc_t          shp;
  acc_t          drv;

  logic [NW-1:0]          n;
  logic [16:0]            t;
  logic [SW-1:0]          nt;
  logic [VW-1:0]          v_in;
  logic [NW-1:0]          cfirst;
  logic [NW:0]            nxt_c;
  logic [NW:0]            nxt_k;
  logic                   c_done;
  logic                   k_done;
  logic signed [BW-1:0]   num;
  logic signed [NW:0]     diff;
  logic [NW-1:0]          mag;
  logic [3:0]             ridx;
  logic signed [BW-1:0]   rcp;
  logic                   skip_num;
  logic signed [ACC_W:0]  dsum;
  acc_t                   drv_sat;
  acc_t                   shp_out;
  logic signed [DW-1:0]   dscl;
  logic signed [DW-1:0]   dscl_sat;

  always_comb begin
    n      = NW'(cfg.order);
    t      = (coord > 17'd65536) ? 17'd65536 : coord;
    nt     = SW'(n) * SW'(t) + SW'(RND);
    v_in   = VW'((nt << UP) >> DN);
    cfirst = (j == '0) ? NW'(1) : '0;

    nxt_c = {1'b0, c} + (NW+1)'(1);
    if (nxt_c == {1'b0, j}) begin
      nxt_c = nxt_c + (NW+1)'(1);
    end
    c_done = nxt_c > {1'b0, n};

    nxt_k = {1'b0, k} + (NW+1)'(1);
    if (nxt_k == {1'b0, j}) begin
      nxt_k = nxt_k + (NW+1)'(1);
    end
    k_done = nxt_k > {1'b0, n};

    num  = $signed({1'b0, v}) - $signed({1'b0, c, {FRAC_BITS{1'b0}}});
    diff = $signed({1'b0, j}) - $signed({1'b0, c});
    mag  = diff[NW] ? NW'(-diff) : NW'(diff);
    ridx = 4'(mag - NW'(1));
    rcp  = $signed({{NW{1'b0}}, RECIP[ridx]});
    if (diff[NW]) begin
      rcp = -rcp;
    end

    skip_num = deriv && (c == k) && !sub;
    op_a     = acc;
    op_b     = sub ? rcp : num;

    dsum = (ACC_W+1)'(drv) + (ACC_W+1)'(acc);
    if (dsum > SUM_HI) begin
      drv_sat = ACC_MAX;
    end else if (dsum < SUM_LO) begin
      drv_sat = ACC_MIN;
    end else begin
      drv_sat = ACC_W'(dsum);
    end

    if (shp > SHP_HI) begin
      shp_out = SHP_HI;
    end else if (shp < SHP_LO) begin
      shp_out = SHP_LO;
    end else begin
      shp_out = shp;
    end

    dscl = DW'(drv) * DW'($signed({1'b0, n}));
    if (dscl > DRV_HI) begin
      dscl_sat = DRV_HI;
    end else if (dscl < DRV_LO) begin
      dscl_sat = DRV_LO;
    end else begin
      dscl_sat = dscl;
    end
  end

  assign busy = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (st != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            v     <= v_in;
            j     <= '0;
            c     <= NW'(1);
            sub   <= 1'b0;
            deriv <= 1'b0;
            acc   <= ACC_ONE;
            st    <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (skip_num) begin
            sub <= 1'b1;
          end else begin
            st <= S_RND;
          end
        end
        S_RND: begin
          acc <= op_res;
          if (!sub) begin
            sub <= 1'b1;
            st  <= S_ISSUE;
          end else begin
            sub <= 1'b0;
            if (c_done) begin
              st <= S_CHAIN;
            end else begin
              c  <= nxt_c[NW-1:0];
              st <= S_ISSUE;
            end
          end
        end
        S_CHAIN: begin
          if (!deriv) begin
            shp <= acc;
            drv <= '0;
            if (cfg.grad) begin
              deriv <= 1'b1;
              k     <= cfirst;
              c     <= cfirst;
              acc   <= ACC_ONE;
              st    <= S_ISSUE;
            end else begin
              st <= S_EMIT;
            end
          end else begin
            drv <= drv_sat;
            if (k_done) begin
              st <= S_EMIT;
            end else begin
              k   <= nxt_k[NW-1:0];
              c   <= cfirst;
              acc <= ACC_ONE;
              st  <= S_ISSUE;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            node_index       <= 4'(j);
            shape_value      <= 32'(shp_out);
            derivative_value <= cfg.grad ? 32'(dscl_sat) : '0;
            last_node        <= (j == n);
            if (j == n) begin
              st <= S_IDLE;
            end else begin
              j     <= j + NW'(1);
              c     <= '0;
              sub   <= 1'b0;
              deriv <= 1'b0;
              acc   <= ACC_ONE;
              st    <= S_ISSUE;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/lagrange_basis_and_derivative_1d_core.sv
// ----------------------------------------------------------------------------
// lagrange_basis_and_derivative_1d_core
// Lagrange basis values and derivatives on equispaced nodes, one shared
// multiplier under a sequencer; config registers and channel handshakes.
// Each step along a chain issues an operand pair in S_ISSUE and takes the
// rounded, saturated product from the shared multiplier in S_RND; with
// gradients off the derivative chains are skipped.
// Results leave one per node as each finishes; no new item during a run.
// Reset clears the sequencer and result valid; order resets to 2, gradients on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lagrange_basis_and_derivative_1d_core import lbd_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  coord_valid,
  output logic                  coord_stall,
  input  logic [16:0]           param_coord,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [3:0]            node_index,
  output logic signed [31:0]    shape_value,
  output logic signed [31:0]    derivative_value,
  output logic                  last_node
);

  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int BW = NW + FRAC_BITS + 1;

  logic [3:0]           order_reg;
  logic                 grad_reg;
  lbd_cfg_t             cfg;
  logic                 busy;
  logic                 start;
  acc_t                 op_a;
  logic signed [BW-1:0] op_b;
  acc_t                 op_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg <= 4'd2;
      grad_reg  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER: order_reg <= cfg_data[3:0];
        REG_GRAD:  grad_reg  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (order_reg == 4'd0) begin
      cfg.order = 4'd1;
    end else if (order_reg > 4'(MAX_ORDER)) begin
      cfg.order = 4'(MAX_ORDER);
    end else begin
      cfg.order = order_reg;
    end
    cfg.grad = grad_reg;
  end

  assign coord_stall = busy;
  assign start       = coord_valid && !coord_stall;

  lbd_ctrl #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .coord            (param_coord),
    .cfg              (cfg),
    .busy             (busy),
    .op_a             (op_a),
    .op_b             (op_b),
    .op_res           (op_res),
    .out_stall        (result_stall),
    .out_valid        (result_valid),
    .node_index       (node_index),
    .shape_value      (shape_value),
    .derivative_value (derivative_value),
    .last_node        (last_node)
  );

  lbd_qmul #(
    .FRAC_BITS (FRAC_BITS),
    .BW        (BW)
  ) u_qmul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .res (op_res)
  );

endmodule

>>> verif/tb_lagrange_basis_and_derivative_1d_core.sv
// ----------------------------------------------------------------------------
// tb_lagrange_basis_and_derivative_1d_core
// Self-checking bench for the 1-D Lagrange basis and derivative core. Each
// accepted coordinate is expanded by a bit-exact fixed-point predictor into
// one expected transaction per node; results are checked in order, field by
// field. Directed coordinates and register settings come first (defaults,
// order extremes and clamping, gradients off, ignored register indexes),
// then output back-pressure and a long randomised run over several settings
// with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lagrange_basis_and_derivative_1d_core import lbd_pkg::*;;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  HOLD_CYCLES = 300;
  localparam longint UNIT     = longint'(1) << FRAC_BITS_DEF;
  localparam logic [16:0] COORD_ONE = 17'd65536;

  typedef struct {
    logic [3:0]         node;
    logic signed [31:0] shape;
    logic signed [31:0] deriv;
    logic               last;
  } node_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  coord_valid = 1'b0;
  logic                  coord_stall;
  logic [16:0]           param_coord = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [3:0]            node_index;
  logic signed [31:0]    shape_value;
  logic signed [31:0]    derivative_value;
  logic                  last_node;

  node_result_t basis_expect[$];
  logic [3:0]   cur_order = 4'd2;
  logic         cur_grad = 1'b1;
  int           errors = 0;
  int           coords_sent = 0;
  int           results_checked = 0;
  int           cycle_count = 0;
  int           stall_mode = 0;
  int           stall_run = 0;
  int           hold_left = 0;
  bit           hold_req = 1'b0;
  int           burst_left = 0;

  lagrange_basis_and_derivative_1d_core u_top (
    .clk              (clk),
    .rst              (rst),
    .coord_valid      (coord_valid),
    .coord_stall      (coord_stall),
    .param_coord      (param_coord),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .node_index       (node_index),
    .shape_value      (shape_value),
    .derivative_value (derivative_value),
    .last_node        (last_node)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // product of two fixed-point values, rounded half away from zero
  function automatic longint round_mul(longint a, longint b);
    longint          p;
    longint          r;
    longint unsigned m;
    bit              neg;
    p = a * b;
    neg = p < 0;
    m = neg ? -p : p;
    m = (m + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
    r = m;
    if (neg) r = -r;
    return clip(r, longint'(ACC_MIN), longint'(ACC_MAX));
  endfunction

  function automatic longint node_recip(int diff);
    int     d;
    longint r;
    d = diff < 0 ? -diff : diff;
    if (d == 0) d = 1;
    r = (UNIT + d / 2) / d;
    return diff < 0 ? -r : r;
  endfunction

  function automatic void predict_basis(logic [16:0] coord);
    int           n;
    longint       t;
    longint       v;
    longint       shp;
    longint       drv;
    longint       term;
    node_result_t r;
    t = coord;
    if (t > COORD_ONE) t = COORD_ONE;
    n = cur_order;
    if (n < 1) n = 1;
    if (n > MAX_ORDER_DEF) n = MAX_ORDER_DEF;
    v = (longint'(n) * t) <<< (FRAC_BITS_DEF - 16);
    for (int j = 0; j <= n; j++) begin
      shp = UNIT;
      drv = 0;
      for (int k = 0; k <= n; k++) begin
        if (k == j) continue;
        shp = round_mul(shp, v - longint'(k) * UNIT);
        shp = round_mul(shp, node_recip(j - k));
        if (cur_grad) begin
          term = UNIT;
          for (int q = 0; q <= n; q++) begin
            if (q == j) continue;
            if (q != k) term = round_mul(term, v - longint'(q) * UNIT);
            term = round_mul(term, node_recip(j - q));
          end
          drv = clip(drv + term, longint'(ACC_MIN), longint'(ACC_MAX));
        end
      end
      drv = clip(drv * n, -64'sd2147483648, 64'sd2147483647);
      shp = clip(shp, -64'sd2147483648, 64'sd2147483647);
      r.node  = j[3:0];
      r.shape = shp[31:0];
      r.deriv = cur_grad ? drv[31:0] : 32'sd0;
      r.last  = (j == n);
      basis_expect.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    node_result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (basis_expect.size() == 0) begin
        $error("node result with nothing expected: node_index %0d", node_index);
        errors++;
      end else begin
        exp_r = basis_expect.pop_front();
        results_checked++;
        if (node_index !== exp_r.node) begin
          $error("node_index: expected %0d, got %0d", exp_r.node, node_index);
          errors++;
        end
        if (shape_value !== exp_r.shape) begin
          $error("shape_value: expected %0d, got %0d", exp_r.shape, shape_value);
          errors++;
        end
        if (derivative_value !== exp_r.deriv) begin
          $error("derivative_value: expected %0d, got %0d", exp_r.deriv,
                 derivative_value);
          errors++;
        end
        if (last_node !== exp_r.last) begin
          $error("last_node: expected %0d, got %0d", exp_r.last, last_node);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall = 1'b1;
    end else begin
      case (stall_mode)
        1: begin
          result_stall = ($urandom_range(0, 3) == 0);
        end
        2: begin
          if (stall_run == 0) begin
            stall_run = $urandom_range(1, 12);
            result_stall = ~result_stall;
          end
          stall_run--;
        end
        default: begin
          result_stall = 1'b0;
        end
      endcase
    end
  end

  task automatic send_coord(logic [16:0] coord);
    coord_valid = 1'b1;
    param_coord = coord;
    do @(posedge clk); while (coord_stall);
    predict_basis(coord);
    coords_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input(int cycles);
    coord_valid = 1'b0;
    param_coord = 17'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ORDER) cur_order = data;
    else if (idx == REG_GRAD) cur_grad = data[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_all_results();
    coord_valid = 1'b0;
    while (basis_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [16:0] pick_coord();
    int sel;
    int n;
    int c;
    sel = $urandom_range(0, 99);
    n = (cur_order < 1) ? 1 : (cur_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : cur_order;
    if (sel < 60) return 17'($urandom_range(0, 65536));
    if (sel < 75) return 17'($urandom_range(0, 131071));
    if (sel < 85) begin
      c = ($urandom_range(0, n) * 65536 + n / 2) / n + $urandom_range(0, 6) - 3;
      return (c < 0) ? 17'd0 : c[16:0];
    end
    if (sel < 92) begin
      case ($urandom_range(0, 2))
        0: return 17'd0;
        1: return 17'd65535;
        default: return COORD_ONE;
      endcase
    end
    return 17'($urandom_range(0, 255));
  endfunction

  task automatic send_bursty(int count);
    for (int i = 0; i < count; i++) begin
      send_coord(pick_coord());
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        if ($urandom_range(0, 4) != 0) pause_input($urandom_range(1, 40));
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_coord(17'd0);
    send_coord(COORD_ONE);
    send_coord(17'd32768);
    send_coord(17'd131071);
    send_coord(17'd1);
    wait_all_results();
  endtask

  task automatic test_order_extremes();
    write_reg(REG_ORDER, 4'd1);
    send_coord(17'd0);
    send_coord(17'd65535);
    send_coord(17'd65537);
    wait_all_results();
    write_reg(REG_ORDER, 4'd8);
    send_coord(17'd0);
    send_coord(17'd24576);
    send_coord(COORD_ONE);
    wait_all_results();
  endtask

  task automatic test_order_clamp();
    write_reg(REG_ORDER, 4'd0);
    send_coord(17'd21845);
    wait_all_results();
    write_reg(REG_ORDER, 4'd15);
    send_coord(17'd40000);
    wait_all_results();
  endtask

  task automatic test_gradient_off();
    write_reg(REG_GRAD, 4'd0);
    send_coord(17'd32768);
    send_coord(COORD_ONE);
    wait_all_results();
    write_reg(REG_ORDER, 4'd3);
    write_reg(REG_GRAD, 4'd3);
    write_reg(REG_GRAD, 4'd2);
    send_coord(17'd98304);
    wait_all_results();
    write_reg(REG_GRAD, 4'd1);
  endtask

  task automatic test_ignored_index();
    for (int i = REG_GRAD + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    send_coord(17'd12345);
    send_coord(17'd65000);
    wait_all_results();
  endtask

  task automatic test_backpressure();
    write_reg(REG_ORDER, 4'd1);
    write_reg(REG_GRAD, 4'd1);
    stall_mode = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) send_coord(pick_coord());
    wait_all_results();
    for (int i = 0; i < 4; i++) send_coord(pick_coord());
    wait_all_results();
  endtask

  task automatic test_random();
    int orders[9]  = '{1, 2, 3, 4, 2, 5, 7, 8, 6};
    int grads[9]   = '{1, 1, 1, 0, 0, 1, 0, 1, 1};
    int counts[9]  = '{80, 80, 50, 50, 40, 30, 30, 10, 20};
    for (int p = 0; p < 9; p++) begin
      write_reg(REG_ORDER, CFG_DATA_W'(orders[p]));
      write_reg(REG_GRAD, CFG_DATA_W'(grads[p]));
      stall_mode = p % 3;
      send_bursty(counts[p]);
      wait_all_results();
    end
    stall_mode = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_order_extremes();
    test_order_clamp();
    test_gradient_off();
    test_ignored_index();
    test_backpressure();
    test_random();
    wait_all_results();
    repeat (2700) @(negedge clk);
    $display("%0d coordinates sent, %0d node results checked", coords_sent,
             results_checked);
    $display("orders 0..15 written, gradients on and off, output held off and stalled");
    if (errors == 0 && basis_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lbd_pkg.sv
src/lbd_qmul.sv
src/lbd_ctrl.sv
src/lagrange_basis_and_derivative_1d_core.sv
verif/tb_lagrange_basis_and_derivative_1d_core.sv
